### hdl/alt_pkg.sv
// ----------------------------------------------------------------------------
// alt_pkg
// Shared types and codes for the allocation leak tracker: command and status
// codes, sequencer states and the record store control group.
// ----------------------------------------------------------------------------
package alt_pkg;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REALLOC = 2'd2,
    CMD_REPORT  = 2'd3
  } cmd_e;

  localparam logic [1:0] ST_TRACKED = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NULL    = 2'd2;
  localparam logic [1:0] ST_NA      = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_MUL,
    S_TRACK,
    S_RPT,
    S_RPT_END
  } state_e;

  // Record store control: one read, record write, freed-mark write.
  typedef struct packed {
    logic rd_en;
    logic rec_we;
    logic freed_we;
    logic freed_val;
  } mem_ctl_t;

endpackage

### hdl/alt_store.sv
// ----------------------------------------------------------------------------
// alt_store
// Record table: address, size and freed mark per entry. One write address
// and one read address per cycle; read data registered.
// ----------------------------------------------------------------------------
module alt_store #(
  parameter int TABLE_DEPTH = 64,
  parameter int IdxW        = 6
) (
  input  logic              clk_i,
  input  alt_pkg::mem_ctl_t ctl_i,
  input  logic [IdxW-1:0]   waddr_i,
  input  logic [63:0]       wrec_addr_i,
  input  logic [63:0]       wrec_size_i,
  input  logic [IdxW-1:0]   raddr_i,
  output logic [63:0]       rd_addr_o,
  output logic [63:0]       rd_size_o,
  output logic              rd_freed_o
);
  import alt_pkg::*;

  logic [63:0] addr_mem  [TABLE_DEPTH];
  logic [63:0] size_mem  [TABLE_DEPTH];
  logic        freed_mem [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.rec_we) begin
      addr_mem[waddr_i] <= wrec_addr_i;
      size_mem[waddr_i] <= wrec_size_i;
    end
    if (ctl_i.rd_en) begin
      rd_addr_o <= addr_mem[raddr_i];
      rd_size_o <= size_mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.freed_we) begin
      freed_mem[waddr_i] <= ctl_i.freed_val;
    end
    if (ctl_i.rd_en) begin
      rd_freed_o <= freed_mem[raddr_i];
    end
  end

endmodule

### hdl/allocation_leak_tracker.sv
// ----------------------------------------------------------------------------
// allocation_leak_tracker
// Tracks allocation records and reports live (leaked) ones on request.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken on a rising edge with start high and
//   busy low. command_i picks alloc, free, realloc or report-and-clear.
//   Result channel: each result beat sits on the result ports for one cycle
//   with result_valid_o high; last_o marks the final beat of a command.
//   The receiver cannot stall; every beat must be taken when shown.
// Steps:
//   alloc   : size, track.
//   free    : scan, mark; the scan stops at the first match.
//   realloc : scan, mark, size, track.
//   report  : scan of every record, one leak beat per live entry.
//   The final beat of a command shows in the first cycle with busy low, and
//   a new command can be taken in that same cycle.
//   The busy time is set by the scan: one table read per cycle through the
//   single read port of the record store, compared by one 64-bit
//   comparator. Sizes come from one 32x32 multiplier, used once per alloc.
// Reset:
//   rst_ni clears the record count and the sequencer; table contents are
//   left as they are and are never read below a zero count.
// ----------------------------------------------------------------------------
module allocation_leak_tracker #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [63:0] address_i,
  input  logic [63:0] new_address_i,
  input  logic [31:0] byte_size_i,
  input  logic [31:0] element_count_i,
  output logic        result_valid_o,
  output logic [1:0]  track_status_o,
  output logic        unknown_block_o,
  output logic        leak_valid_o,
  output logic [63:0] leak_address_o,
  output logic [63:0] leak_size_o,
  output logic        last_o
);
  import alt_pkg::*;

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] Depth = CntW'(TABLE_DEPTH);

  // sequencer and command context
  state_e          state_q, state_d;
  cmd_e            cmd_q, cmd_d;
  logic [63:0]     addr_q, addr_d;
  logic [63:0]     new_q, new_d;
  logic [31:0]     bsize_q, bsize_d;
  logic [31:0]     ecount_q, ecount_d;
  logic [63:0]     size_q, size_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // scan pipeline: read issue stage, compare stage
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic            found_q, found_d;
  logic            unk_q, unk_d;

  // report: one leak held back so the final one can carry last
  logic            pend_q, pend_d;
  logic [63:0]     pend_addr_q, pend_addr_d;
  logic [63:0]     pend_size_q, pend_size_d;

  // result register
  logic            res_vld_q, res_vld_d;
  logic [1:0]      res_st_q, res_st_d;
  logic            res_unk_q, res_unk_d;
  logic            res_leak_q, res_leak_d;
  logic [63:0]     res_addr_q, res_addr_d;
  logic [63:0]     res_size_q, res_size_d;
  logic            res_last_q, res_last_d;

  // store interface
  mem_ctl_t        ctl;
  logic [IdxW-1:0] waddr;
  logic [63:0]     rd_addr;
  logic [63:0]     rd_size;
  logic            rd_freed;

  logic            issue;
  logic            addr_eq;
  logic            release_ok;
  logic [63:0]     product;

  alt_store #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IdxW        (IdxW)
  ) u_store (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .waddr_i     (waddr),
    .wrec_addr_i (new_q),
    .wrec_size_i (size_q),
    .raddr_i     (rd_idx_q[IdxW-1:0]),
    .rd_addr_o   (rd_addr),
    .rd_size_o   (rd_size),
    .rd_freed_o  (rd_freed)
  );

  assign issue      = (rd_idx_q < cnt_q);
  assign addr_eq    = (rd_addr == addr_q);   // the shared comparator
  assign release_ok = found_q && ((cmd_q == CMD_FREE) || (new_q != 64'd0));
  assign product    = {32'd0, bsize_q} * {32'd0, ecount_q};

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    addr_d      = addr_q;
    new_d       = new_q;
    bsize_d     = bsize_q;
    ecount_d    = ecount_q;
    size_d      = size_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    hit_idx_d   = hit_idx_q;
    found_d     = found_q;
    unk_d       = unk_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    pend_size_d = pend_size_q;
    res_vld_d   = 1'b0;
    res_st_d    = res_st_q;
    res_unk_d   = res_unk_q;
    res_leak_d  = res_leak_q;
    res_addr_d  = res_addr_q;
    res_size_d  = res_size_q;
    res_last_d  = res_last_q;
    ctl         = '0;
    waddr       = hit_idx_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d    = cmd_e'(command_i);
          addr_d   = address_i;
          new_d    = new_address_i;
          bsize_d  = byte_size_i;
          ecount_d = element_count_i;
          rd_idx_d = '0;
          found_d  = 1'b0;
          unk_d    = 1'b0;
          pend_d   = 1'b0;
          case (cmd_e'(command_i))
            CMD_ALLOC:   state_d = S_MUL;
            CMD_FREE:    state_d = S_SCAN;
            CMD_REALLOC: state_d = S_SCAN;
            CMD_REPORT:  state_d = S_RPT;
            default:     state_d = S_IDLE;
          endcase
        end
      end

      // first live record whose address matches
      S_SCAN: begin
        ctl.rd_en = issue;
        rd_idx_d  = rd_idx_q + CntW'(issue);
        cmp_vld_d = issue;
        cmp_idx_d = rd_idx_q[IdxW-1:0];
        if (cmp_vld_q && addr_eq && !rd_freed) begin
          found_d   = 1'b1;
          hit_idx_d = cmp_idx_q;
          cmp_vld_d = 1'b0;
          state_d   = S_MARK;
        end else if (!cmp_vld_q && !issue) begin
          state_d = S_MARK;
        end
      end

      S_MARK: begin
        if (release_ok) begin
          ctl.freed_we  = 1'b1;
          ctl.freed_val = 1'b1;
          waddr         = hit_idx_q;
        end
        unk_d = !release_ok;
        if (cmd_q == CMD_FREE) begin
          res_vld_d  = 1'b1;
          res_st_d   = ST_NA;
          res_unk_d  = !release_ok;
          res_leak_d = 1'b0;
          res_addr_d = '0;
          res_size_d = '0;
          res_last_d = 1'b1;
          state_d    = S_IDLE;
        end else begin
          state_d = S_MUL;
        end
      end

      // realloc keeps the element size alone
      S_MUL: begin
        size_d  = (cmd_q == CMD_ALLOC) ? product : {32'd0, bsize_q};
        state_d = S_TRACK;
      end

      S_TRACK: begin
        res_vld_d  = 1'b1;
        res_unk_d  = unk_q;
        res_leak_d = 1'b0;
        res_addr_d = '0;
        res_size_d = '0;
        res_last_d = 1'b1;
        if (cnt_q >= Depth) begin
          res_st_d = ST_FULL;
        end else if (new_q == 64'd0) begin
          res_st_d = ST_NULL;
        end else begin
          res_st_d      = ST_TRACKED;
          ctl.rec_we    = 1'b1;
          ctl.freed_we  = 1'b1;
          ctl.freed_val = 1'b0;
          waddr         = cnt_q[IdxW-1:0];
          cnt_d         = cnt_q + CntW'(1);
        end
        state_d = S_IDLE;
      end

      S_RPT: begin
        ctl.rd_en = issue;
        rd_idx_d  = rd_idx_q + CntW'(issue);
        cmp_vld_d = issue;
        if (cmp_vld_q && !rd_freed) begin
          if (pend_q) begin
            res_vld_d  = 1'b1;
            res_st_d   = ST_NA;
            res_unk_d  = 1'b0;
            res_leak_d = 1'b1;
            res_addr_d = pend_addr_q;
            res_size_d = pend_size_q;
            res_last_d = 1'b0;
          end
          pend_d      = 1'b1;
          pend_addr_d = rd_addr;
          pend_size_d = rd_size;
        end
        if (!cmp_vld_q && !issue) begin
          state_d = S_RPT_END;
        end
      end

      // last leak, or an empty beat when nothing leaked; table emptied
      S_RPT_END: begin
        res_vld_d  = 1'b1;
        res_st_d   = ST_NA;
        res_unk_d  = 1'b0;
        res_leak_d = pend_q;
        res_addr_d = pend_q ? pend_addr_q : 64'd0;
        res_size_d = pend_q ? pend_size_q : 64'd0;
        res_last_d = 1'b1;
        cnt_d      = '0;
        state_d    = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  // payload and context
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    addr_q      <= addr_d;
    new_q       <= new_d;
    bsize_q     <= bsize_d;
    ecount_q    <= ecount_d;
    size_q      <= size_d;
    rd_idx_q    <= rd_idx_d;
    cmp_idx_q   <= cmp_idx_d;
    hit_idx_q   <= hit_idx_d;
    found_q     <= found_d;
    unk_q       <= unk_d;
    pend_q      <= pend_d;
    pend_addr_q <= pend_addr_d;
    pend_size_q <= pend_size_d;
    res_st_q    <= res_st_d;
    res_unk_q   <= res_unk_d;
    res_leak_q  <= res_leak_d;
    res_addr_q  <= res_addr_d;
    res_size_q  <= res_size_d;
    res_last_q  <= res_last_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign result_valid_o  = res_vld_q;
  assign track_status_o  = res_st_q;
  assign unknown_block_o = res_unk_q;
  assign leak_valid_o    = res_leak_q;
  assign leak_address_o  = res_addr_q;
  assign leak_size_o     = res_size_q;
  assign last_o          = res_last_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Depth)
    else $error("record count beyond table depth");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_leak_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_leak_q) |-> (res_st_q == ST_NA && !res_unk_q))
    else $error("leak beat with wrong status");

  a_mid_report : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && !res_last_q) |-> busy)
    else $error("non-final beat outside a report");

endmodule
